// ===== rtl/core/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types, constants and the microcode program of the scalar Kalman
// smoother.
// ----------------------------------------------------------------------------
package skf_pkg;

   // Gain format and division length.
   localparam int GAIN_BITS  = 16;
   localparam int DIV_STEPS  = GAIN_BITS + 1;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   // Configuration port.
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_NOISE     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASUREMENT_NOISE = 1'd1;

   // Program counter.
   localparam int PC_W = 4;
   typedef logic [PC_W-1:0] pc_type;

   // Program step addresses.
   localparam pc_type STEP_IDLE     = 4'd0;
   localparam pc_type STEP_PRED     = 4'd1;
   localparam pc_type STEP_DIV_INIT = 4'd2;
   localparam pc_type STEP_DIV      = 4'd3;
   localparam pc_type STEP_GAIN     = 4'd4;
   localparam pc_type STEP_MAG      = 4'd5;
   localparam pc_type STEP_MUL_UPD  = 4'd6;
   localparam pc_type STEP_UPDATE   = 4'd7;
   localparam pc_type STEP_MUL_COV  = 4'd8;
   localparam pc_type STEP_COV      = 4'd9;
   localparam pc_type STEP_EMIT     = 4'd10;
   localparam pc_type STEP_RETURN   = 4'd11;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_PRED,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_GAIN,
      OP_MAG,
      OP_MUL_UPD,
      OP_UPDATE,
      OP_MUL_COV,
      OP_COV,
      OP_EMIT
   } op_type;

   // Jump conditions: the jump is taken when the condition holds.
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_DIV_MORE,
      COND_OUT_BUSY
   } cond_type;

   // One control word.
   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } ucode_type;

   // Microcode program.
   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE};
      case (pc)
         STEP_IDLE:     w = '{op: OP_LOAD,     cond: COND_NO_REQ,   target: STEP_IDLE};
         STEP_PRED:     w = '{op: OP_PRED,     cond: COND_NEXT,     target: STEP_IDLE};
         STEP_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_NEXT,     target: STEP_IDLE};
         STEP_DIV:      w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: STEP_DIV};
         STEP_GAIN:     w = '{op: OP_GAIN,     cond: COND_NEXT,     target: STEP_IDLE};
         STEP_MAG:      w = '{op: OP_MAG,      cond: COND_NEXT,     target: STEP_IDLE};
         STEP_MUL_UPD:  w = '{op: OP_MUL_UPD,  cond: COND_NEXT,     target: STEP_IDLE};
         STEP_UPDATE:   w = '{op: OP_UPDATE,   cond: COND_NEXT,     target: STEP_IDLE};
         STEP_MUL_COV:  w = '{op: OP_MUL_COV,  cond: COND_NEXT,     target: STEP_IDLE};
         STEP_COV:      w = '{op: OP_COV,      cond: COND_NEXT,     target: STEP_IDLE};
         STEP_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_BUSY, target: STEP_EMIT};
         STEP_RETURN:   w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: STEP_IDLE};
         default:       w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/scalar_kalman_smoother.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_smoother
// One-dimensional Kalman filter over a stream of fixed-point sensor samples,
// run by a small microcoded sequencer over a shared datapath.
// ----------------------------------------------------------------------------
// The block takes one measurement word at a time and returns one word holding
// the updated estimate and the gain used. A new measurement is accepted only
// after the sequencer has finished the last one and returned to its first
// step. The gain is formed by a restoring division, one quotient bit per
// cycle; the two products share one multiplier on separate steps. The input
// stall is low only while the sequencer waits at its first step, and the
// result sits in an output register so that the next measurement may enter
// while it waits to be taken. Noise registers may be written only while idle.
module scalar_kalman_smoother
   import skf_pkg::*;
#(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // Measurement words
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_measurement,
   // Result words
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_estimate,
   output logic [GAIN_BITS-1:0]          rsp_gain,
   // Configuration writes
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_write_data
);

   // Derived widths.
   localparam int NOISE_W = (VALUE_WIDTH > CSR_DATA_W) ? VALUE_WIDTH : CSR_DATA_W;
   localparam int SUM_W   = NOISE_W + 1;
   localparam int REM_W   = SUM_W + 1;
   localparam int MUL_B_W = GAIN_BITS + 1;
   localparam int PROD_W  = VALUE_WIDTH + MUL_B_W;

   // Reset constants, rounded half up.
   localparam logic [63:0] FSCALE          = 64'd1 << FRACTION_BITS;
   localparam logic [63:0] Q_RESET_FULL     = (FSCALE + 64'd500) / 64'd1000;
   localparam logic [63:0] R_RESET_FULL     = (64'd543 * FSCALE + 64'd500) / 64'd1000;
   localparam logic [63:0] PRIOR_RESET_FULL = (64'd2 * FSCALE + 64'd50) / 64'd100;
   localparam logic [CSR_DATA_W-1:0]  Q_RESET     = Q_RESET_FULL[CSR_DATA_W-1:0];
   localparam logic [CSR_DATA_W-1:0]  R_RESET     = R_RESET_FULL[CSR_DATA_W-1:0];
   localparam logic [VALUE_WIDTH-1:0] PRIOR_RESET = PRIOR_RESET_FULL[VALUE_WIDTH-1:0];
   localparam logic [MUL_B_W-1:0]     GAIN_ONE    = MUL_B_W'(1) << GAIN_BITS;

   // Sequencer state.
   pc_type                 pc_ff, pc_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   ucode_type              uword;
   logic                   jump;

   // Configuration and filter state.
   logic [CSR_DATA_W-1:0]  process_noise_ff, process_noise_in;
   logic [CSR_DATA_W-1:0]  measurement_noise_ff, measurement_noise_in;
   logic [VALUE_WIDTH-1:0] prior_ff, prior_in;
   logic [VALUE_WIDTH-1:0] est_ff, est_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [VALUE_WIDTH-1:0] meas_ff, meas_in;
   logic [VALUE_WIDTH-1:0] pred_ff, pred_in;
   logic [SUM_W-1:0]       den_ff, den_in;
   logic                   den_nz_ff, den_nz_in;
   logic [REM_W-1:0]       remainder_ff, remainder_in;
   logic [MUL_B_W-1:0]     quo_ff, quo_in;
   logic [GAIN_BITS-1:0]   gain_ff, gain_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic                   up_ff, up_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [VALUE_WIDTH-1:0] rsp_estimate_ff, rsp_estimate_in;
   logic [GAIN_BITS-1:0]   rsp_gain_ff, rsp_gain_in;

   // Datapath intermediates.
   logic                   req_accept;
   logic                   out_busy;
   logic                   out_load;
   logic [SUM_W-1:0]       pred_sum;
   logic                   div_ge;
   logic [REM_W-1:0]       rem_sub;
   logic [VALUE_WIDTH-1:0] mul_a;
   logic [MUL_B_W-1:0]     mul_b;
   logic [VALUE_WIDTH-1:0] delta;

   // Handshake status.
   assign req_stall  = (pc_ff != STEP_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_busy   = rsp_valid_ff && rsp_stall;
   assign out_load   = (uword.op == OP_EMIT) && !out_busy;

   // Control word fetch and next step.
   assign uword = ucode_rom(pc_ff);

   always_comb begin
      case (uword.cond)
         COND_NEXT:     jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_REQ:   jump = !req_accept;
         COND_DIV_MORE: jump = (div_cnt_ff != DIV_LAST);
         COND_OUT_BUSY: jump = out_busy;
         default:       jump = 1'b1;
      endcase
      pc_in = jump ? uword.target : pc_ff + pc_type'(1);
   end

   // Shared arithmetic.
   assign pred_sum = SUM_W'(prior_ff) + SUM_W'(process_noise_ff);
   assign div_ge   = den_nz_ff && (remainder_ff >= REM_W'(den_ff));
   assign rem_sub  = div_ge ? remainder_ff - REM_W'(den_ff) : remainder_ff;
   assign delta    = prod_ff[GAIN_BITS +: VALUE_WIDTH];

   // The one multiplier: update step first, covariance shrink second.
   always_comb begin
      if (uword.op == OP_MUL_COV) begin
         mul_a = pred_ff;
         mul_b = GAIN_ONE - MUL_B_W'(gain_ff);
      end else begin
         mul_a = mag_ff;
         mul_b = MUL_B_W'(gain_ff);
      end
   end

   // Next values, selected by the current operation.
   always_comb begin
      div_cnt_in           = div_cnt_ff;
      process_noise_in     = process_noise_ff;
      measurement_noise_in = measurement_noise_ff;
      prior_in             = prior_ff;
      est_in               = est_ff;
      meas_in              = meas_ff;
      pred_in              = pred_ff;
      den_in               = den_ff;
      den_nz_in            = den_nz_ff;
      remainder_in         = remainder_ff;
      quo_in               = quo_ff;
      gain_in              = gain_ff;
      mag_in               = mag_ff;
      up_in                = up_ff;
      prod_in              = prod_ff;
      rsp_estimate_in      = rsp_estimate_ff;
      rsp_gain_in          = rsp_gain_ff;

      // Result register empties when taken and refills on the emit step.
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (uword.op)
         OP_LOAD: begin
            if (req_accept) begin
               meas_in = req_measurement;
            end
         end
         OP_PRED: begin
            // Predicted covariance saturates at the largest value.
            pred_in = (|pred_sum[SUM_W-1:VALUE_WIDTH]) ? '1 : pred_sum[VALUE_WIDTH-1:0];
         end
         OP_DIV_INIT: begin
            den_in       = SUM_W'(pred_ff) + SUM_W'(measurement_noise_ff);
            den_nz_in    = (pred_ff != '0) || (measurement_noise_ff != '0);
            remainder_in = REM_W'(pred_ff);
            quo_in       = '0;
            div_cnt_in   = '0;
         end
         OP_DIV_STEP: begin
            // One quotient bit per cycle; a zero denominator leaves it zero.
            quo_in       = {quo_ff[MUL_B_W-2:0], div_ge};
            remainder_in = rem_sub << 1;
            div_cnt_in   = div_cnt_ff + DIV_CNT_W'(1);
         end
         OP_GAIN: begin
            // A gain of exactly one is held at the largest code.
            gain_in = quo_ff[GAIN_BITS] ? '1 : quo_ff[GAIN_BITS-1:0];
         end
         OP_MAG: begin
            up_in  = ($signed(meas_ff) >= $signed(est_ff));
            mag_in = ($signed(meas_ff) >= $signed(est_ff)) ? meas_ff - est_ff
                                                           : est_ff - meas_ff;
         end
         OP_MUL_UPD: begin
            prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
         end
         OP_UPDATE: begin
            // Truncated step keeps the estimate between old value and sample.
            est_in = up_ff ? est_ff + delta : est_ff - delta;
         end
         OP_MUL_COV: begin
            prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
         end
         OP_COV: begin
            prior_in = prod_ff[GAIN_BITS +: VALUE_WIDTH];
         end
         OP_EMIT: begin
            if (out_load) begin
               rsp_valid_in    = 1'b1;
               rsp_estimate_in = est_ff;
               rsp_gain_in     = gain_ff;
            end
         end
         default: begin
         end
      endcase

      // Configuration writes.
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PROCESS_NOISE:     process_noise_in     = csr_write_data;
            CSR_MEASUREMENT_NOISE: measurement_noise_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Control and filter state, loaded with their reset values by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff                <= STEP_IDLE;
         div_cnt_ff           <= '0;
         rsp_valid_ff         <= 1'b0;
         process_noise_ff     <= Q_RESET;
         measurement_noise_ff <= R_RESET;
         prior_ff             <= PRIOR_RESET;
         est_ff               <= '0;
      end else begin
         pc_ff                <= pc_in;
         div_cnt_ff           <= div_cnt_in;
         rsp_valid_ff         <= rsp_valid_in;
         process_noise_ff     <= process_noise_in;
         measurement_noise_ff <= measurement_noise_in;
         prior_ff             <= prior_in;
         est_ff               <= est_in;
      end
   end

   // Datapath working registers.
   always_ff @(posedge clock) begin
      meas_ff         <= meas_in;
      pred_ff         <= pred_in;
      den_ff          <= den_in;
      den_nz_ff       <= den_nz_in;
      remainder_ff    <= remainder_in;
      quo_ff          <= quo_in;
      gain_ff         <= gain_in;
      mag_ff          <= mag_in;
      up_ff           <= up_in;
      prod_ff         <= prod_in;
      rsp_estimate_ff <= rsp_estimate_in;
      rsp_gain_ff     <= rsp_gain_in;
   end

   // Result ports.
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_estimate = $signed(rsp_estimate_ff);
   assign rsp_gain     = rsp_gain_ff;

`ifndef SYNTHESIS
   // An accepted word always starts the prediction step next.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (pc_ff == STEP_PRED))
      else $error("accepted word did not start the prediction step");

   // The division loop never runs past its last quotient bit.
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_DIV) |-> (div_cnt_ff <= DIV_LAST))
      else $error("division loop overran");

   // The new estimate lies between the old estimate and the sample.
   a_est_between: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_UPDATE) |=>
         (up_ff ? ($signed(est_ff) >= $signed($past(est_ff)) &&
                   $signed(est_ff) <= $signed(meas_ff))
                : ($signed(est_ff) <= $signed($past(est_ff)) &&
                   $signed(est_ff) >= $signed(meas_ff))))
      else $error("estimate update left its interval");

   // The kept covariance never exceeds the prediction it came from.
   a_cov_shrinks: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_COV) |=> (prior_ff <= pred_ff))
      else $error("covariance grew in the update");

   // A result appears only out of the emit step.
   a_emit_only: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(pc_ff) == STEP_EMIT))
      else $error("result raised outside the emit step");
`endif

endmodule
